// ===== sv/color_matrix_pixel_filter_core_assert.svh =====
// Assertion macros for the color matrix pixel filter.
// Used by color_matrix_pixel_filter_core; expects i_clk and i_rst_n in scope.
`ifndef COLOR_MATRIX_PIXEL_FILTER_CORE_ASSERT_SVH
`define COLOR_MATRIX_PIXEL_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmpf assertion failed");

// Next-cycle implication, checked outside reset.
`define CMPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cmpf assertion failed");

`endif

// ===== sv/cmpf_pkg.sv =====
// Shared types and constants for the color matrix pixel filter.
// No dependencies; imported by color_matrix_pixel_filter_core.
`timescale 1ns / 1ps

package cmpf_pkg;

    localparam int CMPF_COEF_FRAC_BITS = 14;
    localparam int CMPF_CFG_IDX_W      = 2;
    localparam int CMPF_CFG_DATA_W     = 16;

    localparam logic signed [15:0] CMPF_COS_RESET = 16'sd16384;
    localparam logic signed [15:0] CMPF_SIN_RESET = 16'sd0;

    // Filter select; the unused code acts as hue rotation.
    typedef enum logic [1:0] {
        FM_SEPIA = 2'd0,
        FM_GRAY  = 2'd1,
        FM_HUE   = 2'd2
    } t_filter_mode;

    typedef enum logic [CMPF_CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_COS   = 2'd1,
        CFG_SIN   = 2'd2,
        CFG_ALPHA = 2'd3
    } t_cfg_idx;

    // Per-item sideband carried down the pipeline.
    typedef struct packed {
        logic [7:0]   alpha;
        logic         last;
        t_filter_mode mode;
    } t_side;

endpackage

// ===== sv/color_matrix_pixel_filter_core.sv =====
// Color matrix pixel filter: sepia, Rec.709 gray and hue rotation on RGB(A) items.
// Depends on cmpf_pkg and color_matrix_pixel_filter_core_assert.svh.
// Throughput one item per cycle while the output side is ready (i_m_tready).
// Eight register stages, each with its own valid bit; ready ripples back per stage so
// bubbles are squeezed out and an item is taken while a result waits at the output.
// Reset (i_rst_n low, synchronous) clears all valid bits and loads the register reset
// values: sepia mode, cosine 1.0, sine 0, alpha absent.
`timescale 1ns / 1ps

module color_matrix_pixel_filter_core
    import cmpf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = CMPF_COEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config write port
    input  logic                       i_cfg_we,
    input  logic [CMPF_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CMPF_CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [31:0]                i_s_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                       i_s_tlast,  // frame_end
    // result items
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [31:0]                o_m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                       o_m_tlast   // frame_end_out
);

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int F   = COEF_FRAC_BITS;
    localparam int CW  = F + 3;          // signed coefficient
    localparam int XW  = F + 2;          // |ONE - cf|
    localparam int QW  = F + 1;          // |ONE - cf| / 3
    localparam int QS  = XW + 2;         // reciprocal shift
    localparam int QMW = QS - 1;         // reciprocal width
    localparam int CSW = 16 + F;         // cosine scaled by ONE
    localparam int SKW = 17 + F;         // sine times 1/sqrt3
    localparam int PW  = CW + 9;         // channel product
    localparam int SW  = PW + 2;         // sum of three products
    localparam int NST = 8;

    // ------------------------------------------------------------------
    // Fixed coefficients, round(k * 2^F) with ties upward
    // ------------------------------------------------------------------
    localparam longint SepRr = ((longint'(393) <<< F) * 2 + 1000) / 2000;
    localparam longint SepRg = ((longint'(769) <<< F) * 2 + 1000) / 2000;
    localparam longint SepRb = ((longint'(189) <<< F) * 2 + 1000) / 2000;
    localparam longint SepGr = ((longint'(349) <<< F) * 2 + 1000) / 2000;
    localparam longint SepGg = ((longint'(686) <<< F) * 2 + 1000) / 2000;
    localparam longint SepGb = ((longint'(168) <<< F) * 2 + 1000) / 2000;
    localparam longint SepBr = ((longint'(272) <<< F) * 2 + 1000) / 2000;
    localparam longint SepBg = ((longint'(534) <<< F) * 2 + 1000) / 2000;
    localparam longint SepBb = ((longint'(131) <<< F) * 2 + 1000) / 2000;
    localparam longint LumR  = ((longint'(2126) <<< F) * 2 + 10000) / 20000;
    localparam longint LumG  = ((longint'(7152) <<< F) * 2 + 10000) / 20000;
    localparam longint LumB  = ((longint'(722) <<< F) * 2 + 10000) / 20000;
    localparam longint InvSqrt3 =
        ((64'sd5773502692 <<< F) * 2 + 64'sd10000000000) / 64'sd20000000000;
    localparam longint RecipThree = (longint'(1) <<< QS) / 3;

    localparam logic signed [CW-1:0]  OneC    = CW'(longint'(1) <<< F);
    localparam logic signed [CSW-1:0] CosDiv  = CSW'(16384);
    localparam logic signed [SKW-1:0] SinDiv  = SKW'(16384);
    localparam logic signed [F:0]     KHue    = (F + 1)'(InvSqrt3);
    localparam logic [QMW-1:0]        RecipM  = QMW'(RecipThree);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    t_filter_mode       r_mode;
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;
    logic               r_alpha_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= FM_SEPIA;
            r_cos      <= CMPF_COS_RESET;
            r_sin      <= CMPF_SIN_RESET;
            r_alpha_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:  r_mode     <= t_filter_mode'(i_cfg_data[1:0]);
                CFG_COS:   r_cos      <= $signed(i_cfg_data[15:0]);
                CFG_SIN:   r_sin      <= $signed(i_cfg_data[15:0]);
                CFG_ALPHA: r_alpha_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: per-stage valid, ready ripples from the output
    // ------------------------------------------------------------------
    logic [NST:1] r_vld;
    logic [NST:1] stage_en;
    logic [NST:1] n_vld_src;

    always_comb begin
        stage_en[NST] = !r_vld[NST] || i_m_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k + 1];
        end
    end

    assign n_vld_src  = {r_vld[NST-1:1], i_s_tvalid};
    assign o_s_tready = stage_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NST; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld_src[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel and sideband delay lines
    // ------------------------------------------------------------------
    logic [7:0] r_px [1:5][3];
    t_side      r_side [1:NST];
    t_side      n_side1;

    always_comb begin
        n_side1.alpha = r_alpha_en ? i_s_tdata[31:24] : 8'd0;
        n_side1.last  = i_s_tlast;
        n_side1.mode  = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_px[1][0] <= i_s_tdata[7:0];
            r_px[1][1] <= i_s_tdata[15:8];
            r_px[1][2] <= i_s_tdata[23:16];
            r_side[1]  <= n_side1;
        end
        for (int k = 2; k <= 5; k++) begin
            if (stage_en[k]) begin
                r_px[k] <= r_px[k - 1];
            end
        end
        for (int k = 2; k <= NST; k++) begin
            if (stage_en[k]) begin
                r_side[k] <= r_side[k - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: scale cosine to ONE, sine times 1/sqrt3
    // ------------------------------------------------------------------
    logic signed [CSW-1:0] w_cos_sh;
    logic signed [CW-1:0]  r_cf1;
    logic signed [SKW-1:0] r_sk1;

    assign w_cos_sh = {r_cos, {F{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_cf1 <= CW'(w_cos_sh / CosDiv);   // truncates toward zero
            r_sk1 <= SKW'(r_sin) * SKW'(KHue);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: x = ONE - cf as sign and magnitude; u = sk / 16384
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_x;
    logic [XW-1:0]        r_xabs2;
    logic                 r_xneg2;
    logic signed [CW-1:0] r_cf2;
    logic signed [CW-1:0] r_u2;

    assign w_x = OneC - r_cf1;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_xneg2 <= w_x[CW-1];
            r_xabs2 <= w_x[CW-1] ? XW'(-w_x) : XW'(w_x);
            r_cf2   <= r_cf1;
            r_u2    <= CW'(r_sk1 / SinDiv);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate |x| * M >> QS, low by at most one
    // ------------------------------------------------------------------
    logic [XW+QMW-1:0]    w_qprod;
    logic [QW-1:0]        r_q0_3;
    logic [XW-1:0]        r_xabs3;
    logic                 r_xneg3;
    logic signed [CW-1:0] r_cf3;
    logic signed [CW-1:0] r_u3;

    assign w_qprod = (XW + QMW)'(r_xabs2) * (XW + QMW)'(RecipM);

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_q0_3  <= QW'(w_qprod >> QS);
            r_xabs3 <= r_xabs2;
            r_xneg3 <= r_xneg2;
            r_cf3   <= r_cf2;
            r_u3    <= r_u2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: remainder correction and sign, t = trunc(x / 3)
    // ------------------------------------------------------------------
    logic [XW+2:0]        w_q0x3;
    logic signed [XW+2:0] w_rem3;
    logic [QW-1:0]        w_q;
    logic signed [CW-1:0] w_qs;
    logic signed [CW-1:0] r_t4;
    logic signed [CW-1:0] r_cf4;
    logic signed [CW-1:0] r_u4;

    assign w_q0x3 = (XW + 3)'(r_q0_3) * (XW + 3)'(3);
    assign w_rem3 = $signed((XW + 3)'(r_xabs3) - w_q0x3);
    assign w_q    = r_q0_3 + QW'(w_rem3 >= 3);
    assign w_qs   = $signed(CW'(w_q));

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_t4  <= r_xneg3 ? -w_qs : w_qs;
            r_cf4 <= r_cf3;
            r_u4  <= r_u3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: coefficient matrix for the item's mode
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_diag;
    logic signed [CW-1:0] w_plus;
    logic signed [CW-1:0] w_minus;
    logic signed [CW-1:0] n_k5 [3][3];
    logic signed [CW-1:0] r_k5 [3][3];

    assign w_diag  = r_cf4 + r_t4;
    assign w_plus  = r_t4 + r_u4;
    assign w_minus = r_t4 - r_u4;

    always_comb begin
        case (r_side[4].mode)
            FM_SEPIA: begin
                n_k5[0] = '{CW'(SepRr), CW'(SepRg), CW'(SepRb)};
                n_k5[1] = '{CW'(SepGr), CW'(SepGg), CW'(SepGb)};
                n_k5[2] = '{CW'(SepBr), CW'(SepBg), CW'(SepBb)};
            end
            FM_GRAY: begin
                n_k5[0] = '{CW'(LumR), CW'(LumG), CW'(LumB)};
                n_k5[1] = '{CW'(LumR), CW'(LumG), CW'(LumB)};
                n_k5[2] = '{CW'(LumR), CW'(LumG), CW'(LumB)};
            end
            default: begin
                // hue rotation, also for the unused mode code
                n_k5[0] = '{w_diag, w_minus, w_plus};
                n_k5[1] = '{w_plus, w_diag, w_minus};
                n_k5[2] = '{w_minus, w_plus, w_diag};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_k5 <= n_k5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: nine channel products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_p6 [3][3];

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            for (int o = 0; o < 3; o++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p6[o][c] <= PW'($signed({1'b0, r_px[5][c]})) * PW'(r_k5[o][c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: row sums
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_s7 [3];

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            for (int o = 0; o < 3; o++) begin
                r_s7[o] <= SW'(r_p6[o][0]) + SW'(r_p6[o][1]) + SW'(r_p6[o][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: truncate and clamp to 0..255, output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] w_sh [3];
    logic [7:0]           n_out8 [3];
    logic [7:0]           r_out8 [3];

    always_comb begin
        for (int o = 0; o < 3; o++) begin
            w_sh[o] = r_s7[o] >>> F;
            if (r_s7[o] <= 0) begin
                n_out8[o] = 8'd0;
            end else if (w_sh[o] > SW'(255)) begin
                n_out8[o] = 8'd255;
            end else begin
                n_out8[o] = w_sh[o][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[8]) begin
            r_out8 <= n_out8;
        end
    end

    assign o_m_tvalid = r_vld[NST];
    assign o_m_tdata  = {r_side[NST].alpha, r_out8[2], r_out8[1], r_out8[0]};
    assign o_m_tlast  = r_side[NST].last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "color_matrix_pixel_filter_core_assert.svh"

    // input only blocks when every stage holds an item
    `CMPF_ASSERT_IMP(a_full_when_blocked, !o_s_tready, &r_vld)
    // an accepted item lands in the first stage
    `CMPF_ASSERT_NXT(a_accept_to_stage1, i_s_tvalid && o_s_tready, r_vld[1])
    // divide-by-three estimate is never high and at most one low
    `CMPF_ASSERT_IMP(a_div3_estimate, r_vld[3], !w_rem3[XW+2] && (w_rem3 < 6))
    // gray results carry one value on all three channels
    `CMPF_ASSERT_IMP(a_gray_equal, r_vld[NST] && (r_side[NST].mode == FM_GRAY),
        (r_out8[0] == r_out8[1]) && (r_out8[1] == r_out8[2]))

endmodule

// ===== bench/color_matrix_pixel_filter_core_tb.sv =====
// Self-checking bench for color_matrix_pixel_filter_core: sepia, gray and hue rotation items.
// Depends on cmpf_pkg and the RTL; a bit-exact pixel predictor lives in this file.
`timescale 1ns / 1ps

module color_matrix_pixel_filter_core_tb;
    import cmpf_pkg::*;

    localparam int FRAC         = CMPF_COEF_FRAC_BITS;
    localparam int DRAIN_CYCLES = 12;       // pipeline is 8 deep, plus margin
    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest legal run
    // Mode code the package leaves unnamed; the block treats it as hue rotation.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_pixel;

    // DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    t_cfg_idx                   i_cfg_idx;
    logic [CMPF_CFG_DATA_W-1:0] i_cfg_data;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [31:0]                i_s_tdata;  // red_in, green_in, blue_in, alpha_in
    logic                       i_s_tlast;  // frame_end
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [31:0]                o_m_tdata;  // red_out, green_out, blue_out, alpha_out
    logic                       o_m_tlast;  // frame_end_out

    // Bench copy of the register file
    logic [1:0]         cur_mode;
    logic signed [15:0] cur_cos;
    logic signed [15:0] cur_sin;
    logic               cur_alpha_en;

    t_pixel pending_pixels[$];   // predicted results, oldest first
    bit     idle_on;             // random gaps and stalls enabled
    int     err_count;
    int     items_sent;
    int     results_checked;
    int     items_by_mode[4];
    int     cycle_count;
    int     rx_stall;

    color_matrix_pixel_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Constant num/den in Q.FRAC, rounded half up.
    function automatic longint fixed_coef(longint num, longint den);
        return ((num <<< FRAC) * 2 + den) / (2 * den);
    endfunction

    // Exact dot product, truncated, then clamped to a byte.
    function automatic logic [7:0] clamp_dot(longint r, longint g, longint b,
                                             longint k0, longint k1, longint k2);
        longint sum;
        sum = r * k0 + g * k1 + b * k2;
        if (sum <= 0)
            return 8'd0;
        else if ((sum >>> FRAC) > 255)
            return 8'd255;
        else
            return 8'((sum >>> FRAC));
    endfunction

    function automatic t_pixel predict_pixel(t_pixel px);
        longint one, r, g, b, cf, t, u, dg, pl, mi;
        t_pixel res;
        one = longint'(1) <<< FRAC;
        r   = longint'(px.red);
        g   = longint'(px.green);
        b   = longint'(px.blue);
        if (cur_mode == FM_SEPIA) begin
            res.red   = clamp_dot(r, g, b, fixed_coef(393, 1000), fixed_coef(769, 1000),
                                  fixed_coef(189, 1000));
            res.green = clamp_dot(r, g, b, fixed_coef(349, 1000), fixed_coef(686, 1000),
                                  fixed_coef(168, 1000));
            res.blue  = clamp_dot(r, g, b, fixed_coef(272, 1000), fixed_coef(534, 1000),
                                  fixed_coef(131, 1000));
        end else if (cur_mode == FM_GRAY) begin
            res.red   = clamp_dot(r, g, b, fixed_coef(2126, 10000), fixed_coef(7152, 10000),
                                  fixed_coef(722, 10000));
            res.green = res.red;
            res.blue  = res.red;
        end else begin
            // hue rotation, also taken by the spare mode code
            cf = (longint'(cur_cos) * one) / 16384;
            t  = (one - cf) / 3;
            u  = (longint'(cur_sin) * fixed_coef(64'd5773502692, 64'd10000000000)) / 16384;
            dg = cf + t;
            pl = t + u;
            mi = t - u;
            res.red   = clamp_dot(r, g, b, dg, mi, pl);
            res.green = clamp_dot(r, g, b, pl, dg, mi);
            res.blue  = clamp_dot(r, g, b, mi, pl, dg);
        end
        res.alpha = cur_alpha_en ? px.alpha : 8'd0;
        res.last  = px.last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted output item against the oldest prediction
    // ------------------------------------------------------------------
    t_pixel want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected output item, data %h last %b", o_m_tdata, o_m_tlast);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (o_m_tdata[7:0] !== want.red) begin
                    $error("red_out expected %0d actual %0d", want.red, o_m_tdata[7:0]);
                    err_count++;
                end
                if (o_m_tdata[15:8] !== want.green) begin
                    $error("green_out expected %0d actual %0d", want.green, o_m_tdata[15:8]);
                    err_count++;
                end
                if (o_m_tdata[23:16] !== want.blue) begin
                    $error("blue_out expected %0d actual %0d", want.blue, o_m_tdata[23:16]);
                    err_count++;
                end
                if (o_m_tdata[31:24] !== want.alpha) begin
                    $error("alpha_out expected %0d actual %0d", want.alpha, o_m_tdata[31:24]);
                    err_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("frame_end_out expected %0b actual %0b", want.last, o_m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Output back-pressure: random stall bursts while idling is on.
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            i_m_tready <= 1'b0;
            rx_stall   <= rx_stall - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            rx_stall   <= $urandom_range(0, 5);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_pixels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------

    // Drive one item, wait for the handshake, record its prediction.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic last);
        int gap;
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.alpha = a;
        px.last  = last;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {a, b, g, r};
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
        pending_pixels.push_back(predict_pixel(px));
        items_sent++;
        items_by_mode[cur_mode]++;
    endtask

    task automatic send_random_pixel();
        logic [7:0] ch[3];
        // bias some channels to the rails so the clamps are hit often
        foreach (ch[i]) begin
            case ($urandom_range(0, 5))
                0: ch[i] = 8'd0;
                1: ch[i] = 8'd255;
                default: ch[i] = 8'($urandom);
            endcase
        end
        send_pixel(ch[0], ch[1], ch[2], 8'($urandom), $urandom_range(0, 15) == 0);
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_MODE:  cur_mode     = data[1:0];
            CFG_COS:   cur_cos      = signed'(data);
            CFG_SIN:   cur_sin      = signed'(data);
            CFG_ALPHA: cur_alpha_en = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Full register setup, only ever done with the pipeline empty.
    // Unused upper bits of mode and alpha are filled with noise.
    task automatic set_filter(input logic [1:0] mode, input logic signed [15:0] cosv,
                              input logic signed [15:0] sinv, input logic alpha_en);
        wait_idle();
        write_reg(CFG_MODE, {14'($urandom), mode});
        write_reg(CFG_COS, cosv);
        write_reg(CFG_SIN, sinv);
        write_reg(CFG_ALPHA, {15'($urandom), alpha_en});
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 6))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);                    // anything, beyond +-1 too
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: sepia, alpha absent, so alpha_out must be zero.
    task automatic test_reset_defaults();
        send_pixel(8'd0, 8'd0, 8'd0, 8'hFF, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'hFF, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 8'h5A, 1'b0);
    endtask

    task automatic test_sepia();
        set_filter(FM_SEPIA, 16'sd16384, 16'sd0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 8'h00, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 8'hFF, 1'b1);
        send_pixel(8'd100, 8'd150, 8'd50, 8'hA5, 1'b0);
    endtask

    task automatic test_gray();
        set_filter(FM_GRAY, 16'sd16384, 16'sd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 8'h3C, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'hC3, 1'b1);
        send_pixel(8'd1, 8'd1, 8'd1, 8'hFF, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'h00, 1'b0);
    endtask

    // Hue corners: identity, half turn, +-90 degrees, out-of-range trig,
    // the spare mode code, and alpha on and off in hue mode.
    task automatic test_hue();
        set_filter(FM_HUE, 16'sd16384, 16'sd0, 1'b1);
        send_pixel(8'd200, 8'd100, 8'd50, 8'hFF, 1'b1);
        set_filter(FM_HUE, -16'sd16384, 16'sd0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 8'h80, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'h01, 1'b0);
        set_filter(FM_HUE, 16'sd0, 16'sd16384, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 8'hFF, 1'b1);
        set_filter(FM_HUE, 16'sd0, -16'sd16384, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd128, 8'h7F, 1'b0);
        set_filter(FM_HUE, -16'sd32768, 16'sd32767, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0, 8'hEE, 1'b0);
        send_pixel(8'd10, 8'd200, 8'd30, 8'h11, 1'b1);
        set_filter(MODE_SPARE, 16'sd11585, 16'sd11585, 1'b1);
        send_pixel(8'd255, 8'd128, 8'd0, 8'hAA, 1'b0);
        send_pixel(8'd0, 8'd128, 8'd255, 8'h55, 1'b1);
    endtask

    // Many random register settings, each followed by a burst of random items.
    task automatic test_random_settings(input int n_settings, input int per_setting);
        for (int s = 0; s < n_settings; s++) begin
            set_filter(2'($urandom_range(0, 3)), pick_angle(), pick_angle(),
                       1'($urandom_range(0, 1)));
            repeat (per_setting) send_random_pixel();
        end
    endtask

    // Back-to-back items with both sides always ready.
    task automatic test_full_rate(input int n_items);
        wait_idle();
        idle_on = 1'b0;
        set_filter(FM_HUE, pick_angle(), pick_angle(), 1'b1);
        repeat (n_items) send_random_pixel();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MODE;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        cur_mode     = FM_SEPIA;
        cur_cos      = CMPF_COS_RESET;
        cur_sin      = CMPF_SIN_RESET;
        cur_alpha_en = 1'b0;
        idle_on      = 1'b1;
        rx_stall     = 0;
        err_count    = 0;
        cycle_count  = 0;
        items_sent   = 0;
        results_checked = 0;
        foreach (items_by_mode[i]) items_by_mode[i] = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_sepia();
        test_gray();
        test_hue();
        test_random_settings(10, 100);
        test_full_rate(150);

        wait_idle();
        $display("covered %0d items, %0d results checked", items_sent, results_checked);
        $display("per mode: sepia %0d, gray %0d, hue %0d, spare code %0d",
                 items_by_mode[0], items_by_mode[1], items_by_mode[2], items_by_mode[3]);
        if (err_count == 0 && pending_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
